FILE: src/cor0x_pkg.sv
// Package for the opcode row 0 execute block: opcodes, result layout, timing tables.
package cor0x_pkg;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 96;

  localparam logic [15:0] SpReset = 16'hFFFE;

  // Flag bit positions in the 4-bit flag register
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [3:0] {
    OP_NOP       = 4'h0,
    OP_LD_BC_D16 = 4'h1,
    OP_LD_MBC_A  = 4'h2,
    OP_INC_BC    = 4'h3,
    OP_INC_B     = 4'h4,
    OP_DEC_B     = 4'h5,
    OP_LD_B_D8   = 4'h6,
    OP_RLCA      = 4'h7,
    OP_LD_A16_SP = 4'h8,
    OP_ADD_HL_BC = 4'h9,
    OP_LD_A_MBC  = 4'hA,
    OP_DEC_BC    = 4'hB,
    OP_INC_C     = 4'hC,
    OP_DEC_C     = 4'hD,
    OP_LD_C_D8   = 4'hE,
    OP_RRCA      = 4'hF
  } opcode_e;

  // First declared member lands in the highest bits, so fields are listed top down.
  typedef struct packed {
    logic [6:0]  pad;
    logic [7:0]  flags_out;
    logic [7:0]  reg_l_out;
    logic [7:0]  reg_h_out;
    logic [7:0]  reg_c_out;
    logic [7:0]  reg_b_out;
    logic [7:0]  reg_a_out;
    logic [4:0]  clock_cycles;
    logic [1:0]  instr_bytes;
    logic [7:0]  write_second;
    logic [7:0]  write_first;
    logic [15:0] write_addr;
    logic [1:0]  write_count;
  } result_t;

  function automatic logic [1:0] instr_len(opcode_e op);
    logic [1:0] len;
    unique case (op)
      OP_LD_BC_D16, OP_LD_A16_SP:         len = 2'd3;
      OP_LD_B_D8, OP_LD_C_D8:             len = 2'd2;
      default:                            len = 2'd1;
    endcase
    return len;
  endfunction

  function automatic logic [4:0] instr_cycles(opcode_e op);
    logic [4:0] cyc;
    unique case (op)
      OP_LD_A16_SP:                       cyc = 5'd20;
      OP_LD_BC_D16:                       cyc = 5'd12;
      OP_LD_MBC_A, OP_INC_BC, OP_LD_B_D8, OP_ADD_HL_BC,
      OP_LD_A_MBC, OP_DEC_BC, OP_LD_C_D8: cyc = 5'd8;
      default:                            cyc = 5'd4;
    endcase
    return cyc;
  endfunction

endpackage

FILE: src/cpu_opcode_row0_execute.sv
// Executes one instruction of opcode row 0x00-0x0F per beat, with a skid-buffered result.
//
//  channel   | dir | handshake             | content
//  s_axis    | in  | s_axis_tvalid/tready  | opcode, imm_low, imm_high, mem_read_data
//  m_axis    | out | m_axis_tvalid/tready  | memory writes, length, cycles, A B C H L, flags
//  cfg       | in  | cfg_we_i              | stack pointer, written when high
//
// One instruction per cycle while s_axis_tready is high; each result is registered.
// Register state (A, B, C, H, L, flags) updates at the input beat, so back-to-back
// beats chain through it. A two-entry output (result plus skid register) keeps
// s_axis_tready a pure register; it drops only when both entries are full.
// Reset clears registers and flags, sets SP to 0xFFFE and empties the output.
module cpu_opcode_row0_execute
  import cor0x_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] opcode, [11:4] imm_low, [19:12] imm_high, [27:20] mem_read_data, rest zero
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] write_count, [17:2] write_addr, [25:18] write_first, [33:26] write_second,
  // [35:34] instr_bytes, [40:36] clock_cycles, [48:41] reg_a_out, [56:49] reg_b_out,
  // [64:57] reg_c_out, [72:65] reg_h_out, [80:73] reg_l_out, [88:81] flags_out, rest zero
  output logic [OutWidth-1:0] m_axis_tdata
);

  opcode_e     opcode;
  logic [7:0]  imm_low, imm_high, mem_read_data;

  logic [15:0] sp_q;
  logic [7:0]  a_q, b_q, c_q, h_q, l_q;
  logic [7:0]  a_d, b_d, c_d, h_d, l_d;
  logic [3:0]  flag_q, flag_d;

  logic [15:0] bc, hl;
  logic [16:0] sum_hl;
  logic [12:0] sum_half;
  logic [7:0]  incdec_in, incdec_res;
  logic        is_dec;

  result_t     res;
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_beat, out_free;

  assign opcode        = opcode_e'(s_axis_tdata[3:0]);
  assign imm_low       = s_axis_tdata[11:4];
  assign imm_high      = s_axis_tdata[19:12];
  assign mem_read_data = s_axis_tdata[27:20];

  assign bc       = {b_q, c_q};
  assign hl       = {h_q, l_q};
  assign sum_hl   = {1'b0, hl} + {1'b0, bc};
  assign sum_half = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};

  // Shared 8-bit inc/dec for INC/DEC B and C
  assign is_dec     = (opcode == OP_DEC_B) || (opcode == OP_DEC_C);
  assign incdec_in  = ((opcode == OP_INC_C) || (opcode == OP_DEC_C)) ? c_q : b_q;
  assign incdec_res = is_dec ? (incdec_in - 8'd1) : (incdec_in + 8'd1);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    h_d    = h_q;
    l_d    = l_q;
    flag_d = flag_q;
    res    = '0;
    unique case (opcode)
      OP_NOP: begin
      end
      OP_LD_BC_D16: begin
        b_d = imm_high;
        c_d = imm_low;
      end
      OP_LD_MBC_A: begin
        res.write_count = 2'd1;
        res.write_addr  = bc;
        res.write_first = a_q;
      end
      OP_INC_BC: begin
        {b_d, c_d} = bc + 16'd1;
      end
      OP_DEC_BC: begin
        {b_d, c_d} = bc - 16'd1;
      end
      OP_INC_B, OP_DEC_B, OP_INC_C, OP_DEC_C: begin
        if ((opcode == OP_INC_B) || (opcode == OP_DEC_B)) begin
          b_d = incdec_res;
        end else begin
          c_d = incdec_res;
        end
        flag_d[FlagZ] = (incdec_res == 8'h00);
        flag_d[FlagN] = is_dec;
        flag_d[FlagH] = is_dec ? (incdec_in[3:0] == 4'h0) : (incdec_in[3:0] == 4'hF);
      end
      OP_LD_B_D8: begin
        b_d = imm_low;
      end
      OP_LD_C_D8: begin
        c_d = imm_low;
      end
      OP_RLCA: begin
        a_d    = {a_q[6:0], a_q[7]};
        flag_d = {3'b000, a_q[7]};
      end
      OP_RRCA: begin
        a_d    = {a_q[0], a_q[7:1]};
        flag_d = {3'b000, a_q[0]};
      end
      OP_LD_A16_SP: begin
        res.write_count  = 2'd2;
        res.write_addr   = {imm_high, imm_low};
        res.write_first  = sp_q[7:0];
        res.write_second = sp_q[15:8];
      end
      OP_ADD_HL_BC: begin
        {h_d, l_d}    = sum_hl[15:0];
        flag_d[FlagN] = 1'b0;
        flag_d[FlagH] = sum_half[12];
        flag_d[FlagC] = sum_hl[16];
      end
      OP_LD_A_MBC: begin
        a_d = mem_read_data;
      end
      default: begin
      end
    endcase
    res.instr_bytes  = instr_len(opcode);
    res.clock_cycles = instr_cycles(opcode);
    res.reg_a_out    = a_d;
    res.reg_b_out    = b_d;
    res.reg_c_out    = c_d;
    res.reg_h_out    = h_d;
    res.reg_l_out    = l_d;
    res.flags_out    = {flag_d, 4'h0};
  end

  assign s_axis_tready = !skid_valid_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= SpReset;
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      h_q    <= '0;
      l_q    <= '0;
      flag_q <= '0;
    end else begin
      if (cfg_we_i) begin
        sp_q <= cfg_wdata_i;
      end
      if (in_beat) begin
        a_q    <= a_d;
        b_q    <= b_d;
        c_q    <= c_d;
        h_q    <= h_d;
        l_q    <= l_d;
        flag_q <= flag_d;
      end
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_beat;
      end
    end else if (in_beat) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_beat) begin
        out_q <= res;
      end
    end else if (in_beat) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: src/cor0x_checker.sv
// Port-level checker for the opcode row 0 execute block, with its bind.
module cor0x_checker
  import cor0x_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata
);

  result_t res;
  assign res = m_axis_tdata;

  // A held result beat must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Input side only backs up when a result is already waiting
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // After an input beat, a result beat is always valid on the next cycle
  a_beat_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // Every result carries a table length and cycle count, clean flag padding and a write count below three
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.instr_bytes != 2'd0) && (res.clock_cycles >= 5'd4)
                      && (res.flags_out[3:0] == 4'h0) && (res.write_count != 2'd3))
    else $error("malformed result beat");

endmodule

bind cpu_opcode_row0_execute cor0x_checker u_cor0x_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
